// File: rtl/word_ring_buffer_macros.svh
// Assertion helpers used by the checker file.
`ifndef WORD_RING_BUFFER_MACROS_SVH
`define WORD_RING_BUFFER_MACROS_SVH

// Same-cycle implication.
`define WRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("word ring buffer check failed");

// Next-cycle implication.
`define WRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("word ring buffer check failed");

`endif

// File: rtl/wrb_pkg.sv
package wrb_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = 10;
   localparam int PEEK_W = 10;
   localparam int RUN_W  = 7;
   localparam int EXT_W  = 17;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_PEEK   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } op_kind_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_REDUCE,
      FS_ISSUE
   } front_state_type;

   typedef struct packed {
      op_kind_type       kind;
      logic              status;
      logic [CNT_W-1:0]  done_count;
      logic [CNT_W-1:0]  fill_level;
      logic [CNT_W-1:0]  free_space;
      logic [RUN_W-1:0]  run;
      logic [WORD_W-1:0] data;
   } op_info_type;

   typedef struct packed {
      logic              status;
      logic [WORD_W-1:0] read_word;
      logic [CNT_W-1:0]  done_count;
      logic [CNT_W-1:0]  fill_level;
      logic [CNT_W-1:0]  free_space;
      logic              last;
   } rsp_type;

endpackage

// File: rtl/wrb_ram.sv
module wrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/wrb_queue.sv
module wrb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = AW + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// File: rtl/wrb_front.sv
module wrb_front #(
   parameter int DEPTH = 1024,
   parameter int MAX_RUN = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_command,
   input  logic [wrb_pkg::WORD_W-1:0] req_push_word,
   input  logic [wrb_pkg::PEEK_W-1:0] req_peek_index,
   input  logic [wrb_pkg::CNT_W-1:0]  req_word_count,
   input  logic                       q_full,
   output logic                       enq_valid,
   output wrb_pkg::op_info_type       enq_info,
   output logic [AW-1:0]              enq_addr
);

   localparam int PEEK_SPAN = 2 ** wrb_pkg::PEEK_W;
   localparam int RED_STEPS = (DEPTH >= PEEK_SPAN) ? 1 : $clog2(PEEK_SPAN / DEPTH + 1) + 1;
   localparam int VW        = AW + RED_STEPS + 1;
   localparam int SCW       = $clog2(RED_STEPS + 1);
   localparam int XW        = wrb_pkg::EXT_W;
   localparam int CNT_W     = wrb_pkg::CNT_W;
   localparam int RUN_W     = wrb_pkg::RUN_W;

   wrb_pkg::front_state_type state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [VW-1:0]  sum_ff, sum_in, bound, sum_sub;
   logic [SCW-1:0] step_ff, step_in;
   logic           accept;
   logic [AW:0]    diff, head_sum;
   logic [AW-1:0]  fill, fill_after, free_after;
   logic [XW-1:0]  wc_x, fill_x, n_x, run_x, fill_after_x, free_x;

   assign accept = req_push && !req_full;

   always_comb begin
      diff = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) begin
         diff = diff + (AW + 1)'(DEPTH);
      end
      fill   = diff[AW-1:0];
      fill_x = XW'(fill);
      wc_x   = XW'(req_word_count);
      n_x    = (wc_x < fill_x) ? wc_x : fill_x;
      run_x  = (n_x < XW'(MAX_RUN)) ? n_x : XW'(MAX_RUN);
      head_sum = (AW + 1)'(head_ff) + (AW + 1)'(n_x[AW-1:0]);
      if (head_sum >= (AW + 1)'(DEPTH)) begin
         head_sum = head_sum - (AW + 1)'(DEPTH);
      end
      bound   = VW'(DEPTH) << step_ff;
      sum_sub = (sum_ff >= bound) ? sum_ff - bound : sum_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrb_pkg::FS_IDLE: begin
            if (accept && req_command == wrb_pkg::CMD_PEEK) begin
               state_in = wrb_pkg::FS_REDUCE;
            end
         end
         wrb_pkg::FS_REDUCE: begin
            if (step_ff == '0) begin
               state_in = wrb_pkg::FS_ISSUE;
            end
         end
         wrb_pkg::FS_ISSUE: begin
            if (!q_full) begin
               state_in = wrb_pkg::FS_IDLE;
            end
         end
         default: state_in = wrb_pkg::FS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_full  = 1'b1;
      enq_valid = 1'b0;
      unique case (state_ff)
         wrb_pkg::FS_IDLE: begin
            req_full  = q_full;
            enq_valid = req_push && !q_full && req_command != wrb_pkg::CMD_PEEK;
         end
         wrb_pkg::FS_REDUCE: begin
            req_full = 1'b1;
         end
         wrb_pkg::FS_ISSUE: begin
            enq_valid = !q_full;
         end
         default: req_full = 1'b1;
      endcase
   end

   // classify and update pointers
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      sum_in     = sum_ff;
      step_in    = step_ff;
      fill_after = fill;
      enq_info   = '0;
      enq_addr   = '0;
      enq_info.kind = wrb_pkg::OP_NONE;
      if (state_ff == wrb_pkg::FS_IDLE) begin
         sum_in  = VW'(head_ff) + VW'(req_peek_index);
         step_in = SCW'(RED_STEPS - 1);
      end else if (state_ff == wrb_pkg::FS_REDUCE) begin
         sum_in = sum_sub;
         if (step_ff != '0) begin
            step_in = step_ff - 1'b1;
         end
      end
      if (state_ff == wrb_pkg::FS_ISSUE) begin
         enq_info.kind = wrb_pkg::OP_READ;
         enq_info.run  = RUN_W'(1);
         enq_addr      = sum_ff[AW-1:0];
      end else begin
         unique case (req_command)
            wrb_pkg::CMD_PUSH: begin
               if (fill == AW'(DEPTH - 1)) begin
                  enq_info.status = 1'b1;
               end else begin
                  enq_info.kind = wrb_pkg::OP_WRITE;
                  enq_info.data = req_push_word;
                  enq_addr      = tail_ff;
                  fill_after    = fill + 1'b1;
                  if (accept) begin
                     tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  end
               end
            end
            wrb_pkg::CMD_PEEK: begin
               enq_info.kind = wrb_pkg::OP_NONE;
            end
            wrb_pkg::CMD_DELETE: begin
               enq_info.done_count = n_x[CNT_W-1:0];
               fill_after          = fill - n_x[AW-1:0];
               if (accept) begin
                  head_in = head_sum[AW-1:0];
               end
            end
            wrb_pkg::CMD_READ: begin
               if (run_x != '0) begin
                  enq_info.kind       = wrb_pkg::OP_READ;
                  enq_info.run        = run_x[RUN_W-1:0];
                  enq_info.done_count = run_x[CNT_W-1:0];
                  enq_addr            = head_ff;
               end
            end
            default: enq_info.kind = wrb_pkg::OP_NONE;
         endcase
      end
      free_after          = AW'(DEPTH - 1) - fill_after;
      fill_after_x        = XW'(fill_after);
      free_x              = XW'(free_after);
      enq_info.fill_level = fill_after_x[CNT_W-1:0];
      enq_info.free_space = free_x[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrb_pkg::FS_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      step_ff <= step_in;
   end

endmodule

// File: rtl/wrb_back.sv
module wrb_back #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  wrb_pkg::op_info_type q_info,
   input  logic [AW-1:0]        q_addr,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output wrb_pkg::rsp_type     rsp_data
);

   localparam int RUN_W     = wrb_pkg::RUN_W;
   localparam int OUT_DEPTH = 4;
   localparam int OCW       = $clog2(OUT_DEPTH) + 1;
   localparam int IW        = ((AW > RUN_W) ? AW : RUN_W) + 1;

   logic [RUN_W-1:0] idx_ff, idx_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_use_ram_ff, s1_use_ram_in;
   wrb_pkg::rsp_type s1_meta_ff, s1_meta_in, out_data;
   logic             issue, is_read, last_word;
   logic [IW-1:0]    addr_wrap;
   logic [OCW-1:0]   out_count;
   logic             ram_en, ram_we;
   logic [AW-1:0]    ram_addr;
   logic [wrb_pkg::WORD_W-1:0] ram_rdata;

   always_comb begin
      is_read   = (q_info.kind == wrb_pkg::OP_READ);
      last_word = (idx_ff == q_info.run - 1'b1);
      issue     = !q_empty && (out_count + OCW'(s1_valid_ff) < OCW'(OUT_DEPTH));
      q_pop     = issue && (!is_read || last_word);
      addr_wrap = IW'(q_addr) + IW'(idx_ff);
      if (addr_wrap >= IW'(DEPTH)) begin
         addr_wrap = addr_wrap - IW'(DEPTH);
      end
      ram_en   = issue && q_info.kind != wrb_pkg::OP_NONE;
      ram_we   = (q_info.kind == wrb_pkg::OP_WRITE);
      ram_addr = is_read ? addr_wrap[AW-1:0] : q_addr;
      idx_in   = idx_ff;
      if (q_pop) begin
         idx_in = '0;
      end else if (issue && is_read) begin
         idx_in = idx_ff + 1'b1;
      end
      s1_valid_in              = issue;
      s1_use_ram_in            = is_read;
      s1_meta_in.status        = q_info.status;
      s1_meta_in.read_word     = '0;
      s1_meta_in.done_count    = q_info.done_count;
      s1_meta_in.fill_level    = q_info.fill_level;
      s1_meta_in.free_space    = q_info.free_space;
      s1_meta_in.last          = !is_read || last_word;
      out_data                 = s1_meta_ff;
      out_data.read_word       = s1_use_ram_ff ? ram_rdata : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_use_ram_ff <= s1_use_ram_in;
      s1_meta_ff    <= s1_meta_in;
   end

   wrb_ram #(
      .WIDTH (wrb_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (q_info.data),
      .rdata (ram_rdata)
   );

   wrb_queue #(
      .WIDTH ($bits(wrb_pkg::rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .full      (),
      .count     (out_count)
   );

endmodule

// File: rtl/word_ring_buffer.sv
// Ring FIFO of 32-bit words holding up to DEPTH-1 words, with push, peek at an
// offset from the head, delete of front words, and read of a run of up to MAX_RUN
// words from the head; every result carries the fill level and free space after
// the command. Push, delete and read commands and rejected pushes are taken at
// the input straight from idle; a peek holds the input while its slot address
// is reduced modulo DEPTH in R subtract steps, one step per cycle (R = 1 for
// DEPTH >= 1024, otherwise clog2(1024 / DEPTH + 1) + 1). All storage goes through
// one single-port word RAM, so the back end does at most one memory access per
// cycle and stalls when the output queue has no room; a read run of n words
// delivers n results, one per word. Commands wait in a two-entry queue between
// the pointer logic and the RAM, and results in a four-entry output queue. The
// word store is not cleared by reset; peeking a slot never written returns an unknown word.
module word_ring_buffer #(
   parameter int DEPTH = 1024,
   parameter int MAX_RUN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_push_word,
   input  logic [9:0]  req_peek_index,
   input  logic [9:0]  req_word_count,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_status,
   output logic [31:0] rsp_read_word,
   output logic [9:0]  rsp_done_count,
   output logic [9:0]  rsp_fill_level,
   output logic [9:0]  rsp_free_space,
   output logic        rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int EW = $bits(wrb_pkg::op_info_type) + AW;

   logic                 enq_valid, q_full, q_empty, q_pop;
   wrb_pkg::op_info_type enq_info, q_info;
   logic [AW-1:0]        enq_addr, q_addr;
   wrb_pkg::rsp_type     rsp_data;

   wrb_front #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_push_word  (req_push_word),
      .req_peek_index (req_peek_index),
      .req_word_count (req_word_count),
      .q_full         (q_full),
      .enq_valid      (enq_valid),
      .enq_info       (enq_info),
      .enq_addr       (enq_addr)
   );

   wrb_queue #(
      .WIDTH (EW),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enq_valid),
      .push_data ({enq_info, enq_addr}),
      .pop       (q_pop),
      .pop_data  ({q_info, q_addr}),
      .empty     (q_empty),
      .full      (q_full),
      .count     ()
   );

   wrb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_info    (q_info),
      .q_addr    (q_addr),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_status     = rsp_data.status;
   assign rsp_read_word  = rsp_data.read_word;
   assign rsp_done_count = rsp_data.done_count;
   assign rsp_fill_level = rsp_data.fill_level;
   assign rsp_free_space = rsp_data.free_space;
   assign rsp_last       = rsp_data.last;

endmodule

// File: rtl/wrb_checker.sv
`include "word_ring_buffer_macros.svh"

module wrb_checker #(
   parameter int DEPTH = 1024,
   parameter int MAX_RUN = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [1:0]  req_command,
   input logic [31:0] req_push_word,
   input logic [9:0]  req_peek_index,
   input logic [9:0]  req_word_count,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_status,
   input logic [31:0] rsp_read_word,
   input logic [9:0]  rsp_done_count,
   input logic [9:0]  rsp_fill_level,
   input logic [9:0]  rsp_free_space,
   input logic        rsp_last
);

   localparam logic [9:0] SUM_EXP = 10'((DEPTH - 1) % (2 ** 10));
   localparam logic [9:0] RUN_MAX = 10'(MAX_RUN);

   `WRB_ASSERT_IMPLY(a_level_sum, clock, reset, !rsp_empty, 10'(rsp_fill_level + rsp_free_space) == SUM_EXP)
   `WRB_ASSERT_IMPLY(a_reject_clean, clock, reset, !rsp_empty && rsp_status, rsp_last && rsp_done_count == '0 && rsp_read_word == '0)
   `WRB_ASSERT_IMPLY(a_run_count, clock, reset, !rsp_empty && !rsp_last, rsp_done_count <= RUN_MAX && rsp_done_count >= 10'd2 && !rsp_status)
   `WRB_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_read_word) && $stable(rsp_last))

endmodule

bind word_ring_buffer wrb_checker #(.DEPTH(DEPTH), .MAX_RUN(MAX_RUN)) u_checker (.*);
